// ----- sv/ccrp_pkg.sv -----
package ccrp_pkg;

  localparam logic [7:0] CH_SLASH = 8'h5C;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_XL    = 8'h78;
  localparam logic [7:0] CH_XU    = 8'h58;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_SEVEN = 8'h37;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] VAL_LF   = 8'h0A;
  localparam logic [7:0] VAL_CR   = 8'h0D;
  localparam logic [7:0] VAL_TAB  = 8'h09;

  // Holding slot: bit 8 set marks it empty
  localparam logic [8:0] HELD_EMPTY = 9'h100;
  localparam logic [8:0] HELD_DASH  = {1'b0, CH_DASH};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_REPLAY1,
    ST_PLAIN,
    ST_FLUSH,
    ST_READ
  } state_t;

  typedef enum logic [2:0] {
    EP_NONE,
    EP_SLASH,
    EP_OCT1,
    EP_OCT2,
    EP_HEX0,
    EP_HEX1
  } esc_phase_t;

  typedef enum logic [2:0] {
    VS_BYTE,
    VS_ESC0,
    VS_ESC1,
    VS_SLASH,
    VS_CTRL,
    VS_OCT,
    VS_HEX
  } vsel_t;

  typedef struct packed {
    logic  cap;
    logic  take;
    vsel_t vsel;
    logic  esc0_we;
    logic  esc1_we;
    logic  flush;
    logic  ld_word;
    logic  clear;
  } cmd_t;

  typedef struct packed {
    logic is_zero;
    logic is_slash;
    logic is_ctrl;
    logic is_oct;
    logic is_x;
    logic is_hex;
    logic rd_last;
    logic out_free;
  } stat_t;

  function automatic logic is_oct(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_SEVEN);
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return ((c >= CH_ZERO) && (c <= CH_NINE)) || ((c >= CH_LA) && (c <= CH_LF)) ||
           ((c >= CH_UA) && (c <= CH_UF));
  endfunction

  // Valid only for hex digits; letters of either case share the low nibble
  function automatic logic [3:0] hex_val(input logic [7:0] c);
    return c[6] ? (c[3:0] + 4'd9) : c[3:0];
  endfunction

  function automatic logic [7:0] ctrl_val(input logic [7:0] c);
    logic [7:0] v;
    v = VAL_TAB;
    if (c == CH_N) v = VAL_LF;
    else if (c == CH_R) v = VAL_CR;
    return v;
  endfunction

endpackage

// ----- sv/char_class_range_parser.sv -----
// Character-class range parser. Feed a set description one byte per transfer on
// list_byte; a zero byte ends it. Backslash escapes are decoded (n, r, t; three
// octal digits cut to 8 bits; x or X plus two hex digits; any other byte as
// itself), and "a-b" with b not below a marks the whole range. A broken octal or
// hex escape has its buffered bytes, but not the backslash, replayed as plain
// bytes, and a lone trailing backslash stands for itself. On the zero byte the
// 256-bit membership set leaves as ceil(256/READOUT_BITS) word transfers, lowest
// values first, is_final on the last, and the parser returns to its empty state.
// Timing: the datapath applies at most one character value per cycle, so an
// ordinary byte or a byte that completes or extends an escape passes through
// capture and decode; a byte that breaks an escape is taken again after the
// buffered digits are replayed. The zero byte first drains an open escape, then
// marks held values, and then loads each word as the output side takes it. The
// output register lets a new description start while the final word still waits.
module char_class_range_parser
  import ccrp_pkg::*;
#(
  parameter int READOUT_BITS = 64
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    list_valid,
  output logic                    list_stall,
  input  logic [7:0]              list_byte,
  output logic                    word_valid,
  input  logic                    word_stall,
  output logic [1:0]              word_index,
  output logic [READOUT_BITS-1:0] member_word,
  output logic                    is_final
);

  cmd_t  cmd;
  stat_t stat;

  // Escape tracking and sequencing of replay, flush and readout
  ccrp_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .list_valid (list_valid),
    .list_stall (list_stall),
    .stat       (stat),
    .cmd        (cmd)
  );

  // Holding pair, range mask, membership bits and output register
  ccrp_dpath #(
    .READOUT_BITS (READOUT_BITS)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .list_byte   (list_byte),
    .cmd         (cmd),
    .stat        (stat),
    .word_stall  (word_stall),
    .word_valid  (word_valid),
    .word_index  (word_index),
    .member_word (member_word),
    .is_final    (is_final)
  );

endmodule

// ----- sv/ccrp_ctrl.sv -----
module ccrp_ctrl
  import ccrp_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  list_valid,
  output logic  list_stall,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t     state, state_next;
  esc_phase_t phase, phase_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      phase <= EP_NONE;
    end else begin
      state <= state_next;
      phase <= phase_next;
    end
  end

  assign list_stall = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    phase_next = phase;
    cmd        = '0;
    cmd.vsel   = VS_BYTE;
    case (state)
      ST_IDLE: begin
        if (list_valid) begin
          cmd.cap    = 1'b1;
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        state_next = ST_IDLE;
        if (stat.is_zero) begin
          // drain an open escape, then mark held values
          phase_next = EP_NONE;
          state_next = ST_FLUSH;
          case (phase)
            EP_SLASH: begin
              cmd.take = 1'b1;
              cmd.vsel = VS_SLASH;
            end
            EP_OCT1, EP_HEX0: begin
              cmd.take = 1'b1;
              cmd.vsel = VS_ESC0;
            end
            EP_OCT2, EP_HEX1: begin
              cmd.take   = 1'b1;
              cmd.vsel   = VS_ESC0;
              state_next = ST_REPLAY1;
            end
            default: ;
          endcase
        end else begin
          case (phase)
            EP_SLASH: begin
              phase_next = EP_NONE;
              if (stat.is_ctrl) begin
                cmd.take = 1'b1;
                cmd.vsel = VS_CTRL;
              end else if (stat.is_oct) begin
                cmd.esc0_we = 1'b1;
                phase_next  = EP_OCT1;
              end else if (stat.is_x) begin
                cmd.esc0_we = 1'b1;
                phase_next  = EP_HEX0;
              end else begin
                cmd.take = 1'b1;
              end
            end
            EP_OCT1, EP_HEX0: begin
              if ((phase == EP_OCT1) ? stat.is_oct : stat.is_hex) begin
                cmd.esc1_we = 1'b1;
                phase_next  = (phase == EP_OCT1) ? EP_OCT2 : EP_HEX1;
              end else begin
                cmd.take   = 1'b1;
                cmd.vsel   = VS_ESC0;
                phase_next = EP_NONE;
                state_next = ST_PLAIN;
              end
            end
            EP_OCT2, EP_HEX1: begin
              phase_next = EP_NONE;
              cmd.take   = 1'b1;
              if ((phase == EP_OCT2) ? stat.is_oct : stat.is_hex) begin
                cmd.vsel = (phase == EP_OCT2) ? VS_OCT : VS_HEX;
              end else begin
                cmd.vsel   = VS_ESC0;
                state_next = ST_REPLAY1;
              end
            end
            default: begin
              if (stat.is_slash) phase_next = EP_SLASH;
              else cmd.take = 1'b1;
            end
          endcase
        end
      end
      ST_REPLAY1: begin
        cmd.take   = 1'b1;
        cmd.vsel   = VS_ESC1;
        state_next = stat.is_zero ? ST_FLUSH : ST_PLAIN;
      end
      ST_PLAIN: begin
        // retake the byte that broke the escape; it may open a new one
        if (stat.is_slash) phase_next = EP_SLASH;
        else cmd.take = 1'b1;
        state_next = ST_IDLE;
      end
      ST_FLUSH: begin
        cmd.flush  = 1'b1;
        state_next = ST_READ;
      end
      ST_READ: begin
        if (stat.out_free) begin
          cmd.ld_word = 1'b1;
          if (stat.rd_last) begin
            cmd.clear  = 1'b1;
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// ----- sv/ccrp_dpath.sv -----
module ccrp_dpath
  import ccrp_pkg::*;
#(
  parameter int READOUT_BITS = 64
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic [7:0]              list_byte,
  input  cmd_t                    cmd,
  output stat_t                   stat,
  input  logic                    word_stall,
  output logic                    word_valid,
  output logic [1:0]              word_index,
  output logic [READOUT_BITS-1:0] member_word,
  output logic                    is_final
);

  localparam int WORDS = (256 + READOUT_BITS - 1) / READOUT_BITS;
  localparam int PAD   = WORDS * READOUT_BITS;
  localparam int IDX_W = $clog2(WORDS);

  logic [7:0]       cur_byte, esc0, esc1;
  logic [8:0]       held_first, held_first_next;
  logic [8:0]       held_second, held_second_next;
  logic [255:0]     bitmap, bitmap_next;
  logic [IDX_W-1:0] rd_idx;

  logic [7:0]       val;
  logic             in_range;
  logic [255:0]     range_mask, mark_first, mark_second;
  logic [PAD-1:0]   padded;

  always_ff @(posedge clk) begin
    if (cmd.cap) cur_byte <= list_byte;
    if (cmd.esc0_we) esc0 <= cur_byte;
    if (cmd.esc1_we) esc1 <= cur_byte;
  end

  always_comb begin
    case (cmd.vsel)
      VS_ESC0:  val = esc0;
      VS_ESC1:  val = esc1;
      VS_SLASH: val = CH_SLASH;
      VS_CTRL:  val = ctrl_val(cur_byte);
      VS_OCT:   val = {esc0[1:0], esc1[2:0], cur_byte[2:0]};
      VS_HEX:   val = {hex_val(esc1), hex_val(cur_byte)};
      default:  val = cur_byte;
    endcase
  end

  assign in_range    = !held_first[8] && (held_second == HELD_DASH) && (held_first[7:0] <= val);
  assign range_mask  = ({256{1'b1}} << held_first[7:0]) & ({256{1'b1}} >> (8'd255 - val));
  assign mark_first  = held_first[8]  ? '0 : (256'd1 << held_first[7:0]);
  assign mark_second = held_second[8] ? '0 : (256'd1 << held_second[7:0]);

  always_comb begin
    bitmap_next      = bitmap;
    held_first_next  = held_first;
    held_second_next = held_second;
    if (cmd.clear) begin
      bitmap_next      = '0;
      held_first_next  = HELD_EMPTY;
      held_second_next = HELD_EMPTY;
    end else if (cmd.flush) begin
      bitmap_next = bitmap | mark_first | mark_second;
    end else if (cmd.take) begin
      if (in_range) begin
        bitmap_next      = bitmap | range_mask;
        held_first_next  = HELD_EMPTY;
        held_second_next = HELD_EMPTY;
      end else begin
        bitmap_next      = bitmap | mark_first;
        held_first_next  = held_second;
        held_second_next = {1'b0, val};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bitmap      <= '0;
      held_first  <= HELD_EMPTY;
      held_second <= HELD_EMPTY;
      rd_idx      <= '0;
    end else begin
      bitmap      <= bitmap_next;
      held_first  <= held_first_next;
      held_second <= held_second_next;
      if (cmd.clear) rd_idx <= '0;
      else if (cmd.ld_word) rd_idx <= rd_idx + 1'b1;
    end
  end

  assign padded = PAD'(bitmap);

  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= 1'b0;
    end else if (cmd.ld_word) begin
      word_valid <= 1'b1;
    end else if (!word_stall) begin
      word_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_word) begin
      word_index  <= rd_idx[1:0];
      member_word <= padded[rd_idx * READOUT_BITS +: READOUT_BITS];
      is_final    <= stat.rd_last;
    end
  end

  always_comb begin
    stat.is_zero  = (cur_byte == 8'h00);
    stat.is_slash = (cur_byte == CH_SLASH);
    stat.is_ctrl  = (cur_byte == CH_N) || (cur_byte == CH_R) || (cur_byte == CH_T);
    stat.is_oct   = is_oct(cur_byte);
    stat.is_x     = (cur_byte == CH_XL) || (cur_byte == CH_XU);
    stat.is_hex   = is_hex(cur_byte);
    stat.rd_last  = (rd_idx == IDX_W'(WORDS - 1));
    stat.out_free = !word_valid || !word_stall;
  end

endmodule

// ----- sv/ccrp_checker.sv -----
module ccrp_checker (
  input logic       clk,
  input logic       rst,
  input logic       list_valid,
  input logic       list_stall,
  input logic       word_valid,
  input logic       word_stall,
  input logic [1:0] word_index,
  input logic       is_final
);

  // Every accepted byte is followed by its decode, during which input is stalled
  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    list_valid && !list_stall |=> list_stall)
    else $error("input taken on two consecutive cycles");

  // Readout holds off new input while a non-final word is shown
  a_read_blocks_input: assert property (@(posedge clk) disable iff (rst)
    word_valid && !is_final |-> list_stall)
    else $error("input accepted during readout");

  // No word is shown in the cycle after reset
  a_first_after_reset: assert property (@(posedge clk)
    rst |=> !word_valid)
    else $error("word shown after reset");

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    word_valid && word_stall |=> word_valid && $stable(word_index) && $stable(is_final))
    else $error("stalled word changed");

endmodule

bind char_class_range_parser ccrp_checker u_ccrp_checker (
  .clk        (clk),
  .rst        (rst),
  .list_valid (list_valid),
  .list_stall (list_stall),
  .word_valid (word_valid),
  .word_stall (word_stall),
  .word_index (word_index),
  .is_final   (is_final)
);

// ----- test/testbench.sv -----
module testbench;
  import ccrp_pkg::*;

  localparam int CLK_PERIOD = 20;
  localparam int WORD_BITS = 64;
  localparam int NUM_WORDS = 256 / WORD_BITS;
  localparam int RANDOM_BYTES = 250;

  typedef struct {
    logic [1:0]           idx;
    logic [WORD_BITS-1:0] word;
    logic                 fin;
  } bitmap_word_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 list_valid = 1'b0;
  logic                 list_stall;
  logic [7:0]           list_byte = 8'h00;
  logic                 word_valid;
  logic                 word_stall = 1'b0;
  logic [1:0]           word_index;
  logic [WORD_BITS-1:0] member_word;
  logic                 is_final;

  // Predicted parser state, kept in step with every accepted byte
  logic [255:0] set_bits;
  logic [8:0]   pend_first;
  logic [8:0]   pend_second;
  esc_phase_t   esc_state;
  logic [7:0]   esc_buf [3];

  // Bitmap words still owed by the parser, oldest first
  bitmap_word_t bitmap_q [$];
  bitmap_word_t want;

  int fail_count = 0;
  int bytes_sent = 0;
  int lists_sent = 0;
  int words_seen = 0;

  // Sender pacing and receiver stall pattern
  bit pace_on = 1'b1;
  bit stall_on = 1'b1;
  int burst_left = 0;
  int stall_run = 0;
  bit stall_lvl = 1'b0;

  char_class_range_parser #(
    .READOUT_BITS(WORD_BITS)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .list_valid (list_valid),
    .list_stall (list_stall),
    .list_byte  (list_byte),
    .word_valid (word_valid),
    .word_stall (word_stall),
    .word_index (word_index),
    .member_word(member_word),
    .is_final   (is_final)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Value of a hex digit, or 16 when the byte is not one
  function automatic logic [4:0] digit_value(input logic [7:0] c);
    if (c >= CH_ZERO && c <= CH_NINE) return 5'(c - CH_ZERO);
    if (c >= CH_LA && c <= CH_LF) return 5'(c - CH_LA + 8'd10);
    if (c >= CH_UA && c <= CH_UF) return 5'(c - CH_UA + 8'd10);
    return 5'd16;
  endfunction

  function automatic bit octal_digit(input logic [7:0] c);
    return c >= CH_ZERO && c <= CH_SEVEN;
  endfunction

  // Shift one character value through the pending pair; "first - last" with
  // last not below first fills the whole range and empties the pair.
  function automatic void apply_value(input logic [7:0] ch);
    if (!pend_first[8] && pend_second == HELD_DASH && pend_first[7:0] <= ch) begin
      for (int v = pend_first[7:0]; v <= ch; v++) set_bits[v] = 1'b1;
      pend_first = HELD_EMPTY;
      pend_second = HELD_EMPTY;
    end else begin
      if (!pend_first[8]) set_bits[pend_first[7:0]] = 1'b1;
      pend_first = pend_second;
      pend_second = {1'b0, ch};
    end
  endfunction

  function automatic void apply_plain(input logic [7:0] c);
    if (c == CH_SLASH) esc_state = EP_SLASH;
    else apply_value(c);
  endfunction

  // Replay whatever an unfinished escape has buffered as plain values
  function automatic void unwind_escape();
    case (esc_state)
      EP_SLASH: apply_value(CH_SLASH);
      EP_OCT1, EP_HEX0: apply_value(esc_buf[0]);
      EP_OCT2, EP_HEX1: begin
        apply_value(esc_buf[0]);
        apply_value(esc_buf[1]);
      end
      default: ;
    endcase
    esc_state = EP_NONE;
  endfunction

  function automatic void apply_byte(input logic [7:0] c);
    logic [8:0] oct_val;
    logic [4:0] hi_dig;
    logic [4:0] lo_dig;
    case (esc_state)
      EP_SLASH: begin
        esc_state = EP_NONE;
        if (c == CH_N) apply_value(VAL_LF);
        else if (c == CH_R) apply_value(VAL_CR);
        else if (c == CH_T) apply_value(VAL_TAB);
        else if (octal_digit(c)) begin
          esc_buf[0] = c;
          esc_state = EP_OCT1;
        end else if (c == CH_XL || c == CH_XU) begin
          esc_buf[0] = c;
          esc_state = EP_HEX0;
        end else apply_value(c);
      end
      EP_OCT1: begin
        if (octal_digit(c)) begin
          esc_buf[1] = c;
          esc_state = EP_OCT2;
        end else begin
          unwind_escape();
          apply_plain(c);
        end
      end
      EP_OCT2: begin
        if (octal_digit(c)) begin
          esc_state = EP_NONE;
          // Three digits give nine bits; keep the low byte
          oct_val = {esc_buf[0][2:0], esc_buf[1][2:0], c[2:0]};
          apply_value(oct_val[7:0]);
        end else begin
          unwind_escape();
          apply_plain(c);
        end
      end
      EP_HEX0: begin
        if (digit_value(c) != 5'd16) begin
          esc_buf[1] = c;
          esc_state = EP_HEX1;
        end else begin
          unwind_escape();
          apply_plain(c);
        end
      end
      EP_HEX1: begin
        if (digit_value(c) != 5'd16) begin
          esc_state = EP_NONE;
          hi_dig = digit_value(esc_buf[1]);
          lo_dig = digit_value(c);
          apply_value({hi_dig[3:0], lo_dig[3:0]});
        end else begin
          unwind_escape();
          apply_plain(c);
        end
      end
      default: apply_plain(c);
    endcase
  endfunction

  function automatic void clear_parser();
    set_bits = '0;
    pend_first = HELD_EMPTY;
    pend_second = HELD_EMPTY;
    esc_state = EP_NONE;
    esc_buf = '{default: 8'h00};
  endfunction

  // Terminator: flush the escape and the pending pair, then owe the bitmap
  function automatic void close_list();
    bitmap_word_t w_item;
    unwind_escape();
    if (!pend_first[8]) set_bits[pend_first[7:0]] = 1'b1;
    if (!pend_second[8]) set_bits[pend_second[7:0]] = 1'b1;
    for (int w = 0; w < NUM_WORDS; w++) begin
      w_item.idx = 2'(w);
      w_item.word = set_bits[w*WORD_BITS +: WORD_BITS];
      w_item.fin = (w == NUM_WORDS - 1);
      bitmap_q.push_back(w_item);
    end
    clear_parser();
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Send one byte: open a new burst after a random gap when the old one is
  // used up, hold the byte until the parser takes the transfer, then predict.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = 0;
      if (pace_on && $urandom_range(0, 3) != 0) gap = $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk);
        list_valid = 1'b0;
        list_byte = 8'($urandom);
      end
    end
    burst_left--;
    @(negedge clk);
    list_valid = 1'b1;
    list_byte = b;
    @(posedge clk);
    while (list_stall) @(posedge clk);
    bytes_sent++;
    if (b == 8'h00) begin
      lists_sent++;
      close_list();
    end else apply_byte(b);
  endtask

  // Send a description given as text, then its terminator
  task automatic send_list(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    send_byte(8'h00);
  endtask

  // Drop valid and wait until every owed bitmap word has come back
  task automatic drain();
    @(negedge clk);
    list_valid = 1'b0;
    burst_left = 0;
    while (bitmap_q.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255)); while (c == CH_SLASH);
    return c;
  endfunction

  function automatic logic [7:0] octal_char();
    return CH_ZERO + 8'($urandom_range(0, 7));
  endfunction

  function automatic logic [7:0] hex_char();
    logic [3:0] v;
    v = 4'($urandom_range(0, 15));
    if (v < 10) return CH_ZERO + 8'(v);
    return ($urandom_range(0, 1) ? CH_LA : CH_UA) + 8'(v) - 8'd10;
  endfunction

  // One random token of a description; most are well formed, some are
  // deliberately cut short so the next token breaks them.
  task automatic rand_token();
    int kind;
    logic [7:0] a;
    logic [7:0] b;
    kind = $urandom_range(0, 11);
    case (kind)
      0, 1, 2: send_byte(plain_char());
      3: begin
        a = plain_char();
        if ($urandom_range(0, 3) == 0) b = plain_char();
        else b = a + 8'($urandom_range(0, 255 - a));
        if (b == CH_SLASH) b = a;
        send_byte(a);
        send_byte(CH_DASH);
        send_byte(b);
      end
      4: begin
        send_byte(CH_SLASH);
        case ($urandom_range(0, 2))
          0: send_byte(CH_N);
          1: send_byte(CH_R);
          default: send_byte(CH_T);
        endcase
      end
      5: begin
        send_byte(CH_SLASH);
        repeat (3) send_byte(octal_char());
      end
      6: begin
        send_byte(CH_SLASH);
        send_byte($urandom_range(0, 1) ? CH_XL : CH_XU);
        repeat (2) send_byte(hex_char());
      end
      7: begin
        send_byte(CH_SLASH);
        send_byte(8'($urandom_range(1, 255)));
      end
      8: begin
        send_byte(CH_SLASH);
        repeat ($urandom_range(1, 2)) send_byte(octal_char());
      end
      9: begin
        send_byte(CH_SLASH);
        send_byte(CH_XL);
        if ($urandom_range(0, 1)) send_byte(hex_char());
      end
      10: send_byte(CH_DASH);
      default: begin
        // Range whose ends are both escapes
        send_byte(CH_SLASH);
        send_byte(CH_XU);
        repeat (2) send_byte(hex_char());
        send_byte(CH_DASH);
        send_byte(CH_SLASH);
        repeat (3) send_byte(octal_char());
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  task automatic test_plain_and_ranges();
    send_list("");
    send_list("abc");
    send_list("a-z0-9");
    send_list("z-a");
    send_list("-a-");
    // Widest plain range, then the top plain byte together with 0x80
    send_byte(8'h01);
    send_byte(CH_DASH);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h80);
    send_byte(8'h00);
    drain();
  endtask

  task automatic test_escapes();
    send_list("\\n\\r\\t");
    send_list("\\101\\777\\000");
    send_list("\\x4f\\XaB\\x00\\xFF");
    send_list("\\q\\\\\\-");
    send_list("\\000-\\377");
    drain();
  endtask

  task automatic test_broken_escapes();
    send_list("\\18");
    send_list("\\12z");
    send_list("\\xg");
    send_list("\\x4\\n");
    send_list("\\7\\");
    // Terminator arriving inside each kind of escape
    send_list("ab\\");
    send_list("\\12");
    send_list("\\x");
    send_list("\\XA");
    drain();
  endtask

  task automatic test_random_lists();
    int start_bytes;
    int ntok;
    start_bytes = bytes_sent;
    while (bytes_sent - start_bytes < RANDOM_BYTES) begin
      // Hold some lists with no pacing and no stalls at all
      pace_on = ($urandom_range(0, 4) != 0);
      stall_on = ($urandom_range(0, 4) != 0);
      if ($urandom_range(0, 5) == 0) begin
        repeat ($urandom_range(1, 10)) send_byte(8'($urandom_range(1, 255)));
      end else begin
        ntok = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 8);
        repeat (ntok) rand_token();
      end
      send_byte(8'h00);
    end
    drain();
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: stall in runs of random length and level
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (stall_run == 0) begin
      stall_run = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 20) : $urandom_range(1, 6);
      stall_lvl = stall_on && ($urandom_range(0, 2) == 0);
    end
    stall_run--;
    word_stall = stall_lvl;
  end

  // Check each bitmap word transfer against the oldest owed word
  always @(posedge clk) begin
    if (!rst && word_valid === 1'b1 && !word_stall) begin
      if (bitmap_q.size() == 0) begin
        $error("unexpected bitmap word: word_index %0d member_word %h", word_index,
               member_word);
        fail_count++;
      end else begin
        want = bitmap_q.pop_front();
        words_seen++;
        if (word_index !== want.idx) begin
          $error("word_index: expected %0d, got %0d", want.idx, word_index);
          fail_count++;
        end
        if (member_word !== want.word) begin
          $error("member_word: expected %h, got %h", want.word, member_word);
          fail_count++;
        end
        if (is_final !== want.fin) begin
          $error("is_final: expected %0d, got %0d", want.fin, is_final);
          fail_count++;
        end
      end
    end
  end

  initial begin
    clear_parser();
    repeat (7) @(negedge clk);
    rst = 1'b0;

    test_plain_and_ranges();
    test_escapes();
    test_broken_escapes();
    test_random_lists();

    if (bitmap_q.size() != 0) begin
      $error("%0d bitmap words never arrived", bitmap_q.size());
      fail_count++;
    end
    $display("Run covered %0d description bytes in %0d lists (plain, ranges, escapes,",
             bytes_sent, lists_sent);
    $display("broken escapes, random token mixes); %0d bitmap words compared.", words_seen);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog far beyond the slowest legal run
  initial begin
    #(200000 * CLK_PERIOD);
    $display("FAIL");
    $finish;
  end

endmodule

// ----- char_class_range_parser.f -----
sv/ccrp_pkg.sv
sv/ccrp_ctrl.sv
sv/ccrp_dpath.sv
sv/char_class_range_parser.sv
sv/ccrp_checker.sv
test/testbench.sv
